// ===== hw/rtl/sbot_pkg.sv =====
// Shared types, widths and constants for the segment/box overlap test.
// No dependencies; every other file but sbot_hit_if uses this package.
`default_nettype none

package sbot_pkg;

	localparam int COORD_W = 32;   // Q16.16 coordinate
	localparam int FRAC_W  = 17;   // Q1.16 reach fraction
	localparam int FRAC_SH = 16;
	localparam int IDX_W   = 3;
	localparam int DIFF_W  = 33;   // end - start
	localparam int PROD_W  = 51;   // fraction * (end - start)
	localparam int D_W     = 33;   // trimmed direction
	localparam int S_W     = 33;   // min + max
	localparam int E_W     = 33;   // max - min
	localparam int M_W     = 35;   // 2*start + d - min - max
	localparam int AD_W    = 34;   // |d| + 1
	localparam int FL_W    = 36;   // face axis compare width
	localparam int XP_W    = 68;   // cross axis products
	localparam int XD_W    = 69;   // difference / sum of two products
	localparam int XS_W    = 70;   // difference plus sum

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_SH);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [IDX_W-1:0] {
		REG_START_X,
		REG_START_Y,
		REG_START_Z,
		REG_END_X,
		REG_END_Y,
		REG_END_Z,
		REG_REACH
	} reg_idx_t;

	// Axis pairs of the three cross-product axes: x cross d uses (y, z), and so on.
	localparam logic [1:0] AX_A [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] AX_B [3] = '{2'd2, 2'd0, 2'd1};

	typedef struct {
		coord_t start [3];
		coord_t stop [3];
		logic [FRAC_W-1:0] frac;
	} seg_cfg_t;

	typedef struct {
		coord_t lo [3];
		coord_t hi [3];
	} box_t;

	typedef struct {
		logic signed [D_W-1:0] d [3];
		logic signed [M_W-1:0] m [3];
		logic signed [E_W-1:0] e [3];
		logic [AD_W-1:0]       ad [3];
	} axes_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbot_box_if.sv =====
// Input channel: one axis-aligned box per word.
// Depends on sbot_pkg for the coordinate type.
`default_nettype none

interface sbot_box_if;
	logic            valid;
	logic            ready;
	sbot_pkg::coord_t box_min_x;
	sbot_pkg::coord_t box_min_y;
	sbot_pkg::coord_t box_min_z;
	sbot_pkg::coord_t box_max_x;
	sbot_pkg::coord_t box_max_y;
	sbot_pkg::coord_t box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/sbot_hit_if.sv =====
// Output channel: one hit flag per word.
// No dependencies.
`default_nettype none

interface sbot_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbot_cfg.sv =====
// Segment configuration registers: start, end and reach fraction.
// Depends on sbot_pkg.
`default_nettype none

module sbot_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [sbot_pkg::IDX_W-1:0]      wr_index,
	input  logic [sbot_pkg::COORD_W-1:0]    wr_data,
	output sbot_pkg::seg_cfg_t              seg
);
	import sbot_pkg::*;

	seg_cfg_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				seg_q.start[i] <= '0;
				seg_q.stop[i]  <= '0;
			end
			seg_q.frac <= FRAC_ONE;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_START_X: seg_q.start[0] <= wr_data;
				REG_START_Y: seg_q.start[1] <= wr_data;
				REG_START_Z: seg_q.start[2] <= wr_data;
				REG_END_X:   seg_q.stop[0]  <= wr_data;
				REG_END_Y:   seg_q.stop[1]  <= wr_data;
				REG_END_Z:   seg_q.stop[2]  <= wr_data;
				REG_REACH:   seg_q.frac     <= wr_data[FRAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign seg = seg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbot_front.sv =====
// Stages 1 and 2: trim the segment direction and center the box on the segment.
// Depends on sbot_pkg.
`default_nettype none

module sbot_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sbot_pkg::seg_cfg_t seg,
	input  logic               in_valid,
	input  sbot_pkg::box_t     box,
	output logic               out_valid,
	output sbot_pkg::axes_t    axes
);
	import sbot_pkg::*;

	logic [FRAC_W-1:0]        frac_c;
	logic signed [DIFF_W-1:0] diff_c [3];
	logic signed [PROD_W-1:0] prod_c [3];
	logic signed [E_W-1:0]    e_c [3];
	logic signed [S_W-1:0]    s_c [3];

	logic                     v_s1;
	logic signed [PROD_W-1:0] p_s1 [3];
	logic signed [E_W-1:0]    e_s1 [3];
	logic signed [S_W-1:0]    s_s1 [3];

	logic signed [D_W-1:0]    d_c [3];
	logic signed [M_W-1:0]    m_c [3];
	logic [AD_W-1:0]          ad_c [3];

	logic                     v_s2;
	axes_t                    ax_s2;

	// Stage 1: one fraction multiply per axis, box extent and corner sum.
	always_comb begin
		frac_c = (seg.frac > FRAC_ONE) ? FRAC_ONE : seg.frac;
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = DIFF_W'(seg.stop[i]) - DIFF_W'(seg.start[i]);
			prod_c[i] = $signed({1'b0, frac_c}) * diff_c[i];
			e_c[i]    = E_W'(box.hi[i]) - E_W'(box.lo[i]);
			s_c[i]    = S_W'(box.hi[i]) + S_W'(box.lo[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= prod_c;
			e_s1 <= e_c;
			s_s1 <= s_c;
		end
	end

	// Stage 2: the arithmetic shift floors the product, so d is exact.
	// ad is |d| + 1, folded into one add: -d + 1 equals ~d + 2.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i]  = p_s1[i][D_W+FRAC_SH-1:FRAC_SH];
			m_c[i]  = (M_W'(seg.start[i]) <<< 1) + M_W'(d_c[i]) - M_W'(s_s1[i]);
			ad_c[i] = d_c[i][D_W-1] ? (AD_W'(~d_c[i]) + AD_W'(2))
			                        : (AD_W'(d_c[i]) + AD_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2.d  <= d_c;
			ax_s2.m  <= m_c;
			ax_s2.e  <= e_s1;
			ax_s2.ad <= ad_c;
		end
	end

	assign out_valid = v_s2;
	assign axes      = ax_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/sbot_cross.sv =====
// Stages 3 to 5: face-axis tests, cross-axis products and the final compare.
// Depends on sbot_pkg.
`default_nettype none

module sbot_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  sbot_pkg::axes_t axes,
	output logic            out_valid,
	output logic            hit
);
	import sbot_pkg::*;

	logic signed [M_W-1:0]  mag_c [3];
	logic signed [FL_W-1:0] lim_c [3];
	logic [2:0]             face_sep_c;
	logic signed [XP_W-1:0] pa_c [3];
	logic signed [XP_W-1:0] pb_c [3];
	logic signed [XP_W-1:0] ra_c [3];
	logic signed [XP_W-1:0] rb_c [3];

	logic                   v_s3;
	logic                   face_s3;
	logic signed [XP_W-1:0] pa_s3 [3];
	logic signed [XP_W-1:0] pb_s3 [3];
	logic signed [XP_W-1:0] ra_s3 [3];
	logic signed [XP_W-1:0] rb_s3 [3];

	logic signed [XD_W-1:0] df_c [3];
	logic signed [XD_W-1:0] rh_c [3];

	logic                   v_s4;
	logic                   face_s4;
	logic signed [XD_W-1:0] df_s4 [3];
	logic signed [XD_W-1:0] rh_s4 [3];

	logic signed [XS_W-1:0] sum_c [3];
	logic [2:0]             cross_sep_c;
	logic                   hit_c;

	logic                   v_s5;
	logic                   hit_s5;

	// Stage 3. A face axis separates when |m| > e + |d|, that is |m| >= e + ad.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i]      = axes.m[i][M_W-1] ? -axes.m[i] : axes.m[i];
			lim_c[i]      = FL_W'(axes.e[i]) + FL_W'($signed({1'b0, axes.ad[i]}));
			face_sep_c[i] = FL_W'(mag_c[i]) >= lim_c[i];
		end
		for (int k = 0; k < 3; k++) begin
			pa_c[k] = axes.m[AX_A[k]] * axes.d[AX_B[k]];
			pb_c[k] = axes.m[AX_B[k]] * axes.d[AX_A[k]];
			ra_c[k] = axes.e[AX_A[k]] * $signed({1'b0, axes.ad[AX_B[k]]});
			rb_c[k] = axes.e[AX_B[k]] * $signed({1'b0, axes.ad[AX_A[k]]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s3 <= ~|face_sep_c;
			pa_s3   <= pa_c;
			pb_s3   <= pb_c;
			ra_s3   <= ra_c;
			rb_s3   <= rb_c;
		end
	end

	// Stage 4: cross term and its slack bound.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			df_c[k] = XD_W'(pa_s3[k]) - XD_W'(pb_s3[k]);
			rh_c[k] = XD_W'(ra_s3[k]) + XD_W'(rb_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s4 <= face_s3;
			df_s4   <= df_c;
			rh_s4   <= rh_c;
		end
	end

	// Stage 5: |df| > rh is split into df > rh or -df > rh, so no abs is needed.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k]       = XS_W'(df_s4[k]) + XS_W'(rh_s4[k]);
			cross_sep_c[k] = (df_s4[k] > rh_s4[k]) || sum_c[k][XS_W-1];
		end
		hit_c = face_s4 & ~|cross_sep_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= hit_c;
		end
	end

	assign out_valid = v_s5;
	assign hit       = hit_s5;

	a_face_miss: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 && !face_s4 |=> v_s5 && !hit_s5)
		else $error("face separation did not force a miss");

	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en && !v_s4 |=> !v_s5)
		else $error("output valid without an item in stage 4");

	a_face_carry: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |=> v_s4 && (face_s4 == $past(face_s3)))
		else $error("face result lost between stages 3 and 4");

endmodule

`default_nettype wire

// ===== hw/rtl/segment_box_overlap_test.sv =====
// Top level of the segment versus axis-aligned box overlap test.
// Depends on sbot_pkg, sbot_box_if, sbot_hit_if, sbot_cfg, sbot_front and sbot_cross.
//
//   channel   dir   handshake          word
//   box       in    valid / ready      box_min_x..z, box_max_x..z (signed Q16.16)
//   res       out   valid / ready      hit
//   config    in    wr_en (no stall)   wr_index, wr_data
//
// One box word enters every cycle while the output is not stalled; its hit word is
// valid once it has passed all five stage registers.
// The five-stage pipeline: the fraction multiply, centering, the face tests with the
// twelve cross-axis multipliers, the cross-term sums and the final compare.
// Reset clears all stage valid bits and loads the segment registers.
// A result not taken freezes every stage, and box.ready drops with it.
`default_nettype none

module segment_box_overlap_test (
	input  logic                         clk,
	input  logic                         arst_n,
	sbot_box_if.sink                     box,
	sbot_hit_if.source                   res,
	input  logic                         wr_en,
	input  logic [sbot_pkg::IDX_W-1:0]   wr_index,
	input  logic [sbot_pkg::COORD_W-1:0] wr_data
);
	import sbot_pkg::*;

	seg_cfg_t seg;
	box_t     box_c;
	axes_t    axes;
	logic     en;
	logic     front_valid;
	logic     out_valid;
	logic     out_hit;

	// The whole pipeline advances together unless the output word is stuck.
	assign en        = !out_valid || res.ready;
	assign box.ready = en;

	assign box_c.lo[0] = box.box_min_x;
	assign box_c.lo[1] = box.box_min_y;
	assign box_c.lo[2] = box.box_min_z;
	assign box_c.hi[0] = box.box_max_x;
	assign box_c.hi[1] = box.box_max_y;
	assign box_c.hi[2] = box.box_max_z;

	sbot_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.seg      (seg)
	);

	// Stages 1 and 2: trimmed direction d, extent e, center offset m and |d| + 1.
	sbot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.seg       (seg),
		.in_valid  (box.valid),
		.box       (box_c),
		.out_valid (front_valid),
		.axes      (axes)
	);

	// Stages 3 to 5: the six separating-axis tests and the output register.
	sbot_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.axes      (axes),
		.out_valid (out_valid),
		.hit       (out_hit)
	);

	assign res.valid = out_valid;
	assign res.hit   = out_hit;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for segment_box_overlap_test: streams boxes against a programmed
// segment and checks each hit word against a local prediction.
// Depends on sbot_pkg, sbot_box_if, sbot_hit_if and the block's RTL.

module tb;
	import sbot_pkg::*;

	// Pipeline depth as documented at the block's top level.
	localparam int LATENCY = 5;
	localparam int SETTLE = 4 * LATENCY + 10;
	// The limit leaves a wide margin over the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 108;
	localparam int PRINT_CAP = 40;

	// Index 7 has no register behind it; writes there must be dropped.
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam coord_t CMIN = 32'sh8000_0000;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;

	// How the segment of a random phase is chosen.
	typedef enum int {
		SEG_WIDE,    // any coordinates at all
		SEG_MID,     // within about +-256.0
		SEG_NEAR,    // within about +-4.0
		SEG_CORNER,  // coordinates at the ends of the range
		SEG_POINT    // start and end coincide
	} seg_style_t;

	// One outstanding hit word: the box's serial number and its predicted flag.
	typedef struct {
		int unsigned serial;
		logic hit;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [COORD_W-1:0] wr_data;

	sbot_box_if box_ch ();
	sbot_hit_if hit_ch ();

	segment_box_overlap_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.box(box_ch),
		.res(hit_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Shadow copy of the segment registers, as the block should hold them.
	seg_cfg_t seg;

	box_t boxes_waiting[$];   // boxes not yet offered to the block
	verdict_t hits_due[$];    // predicted hit words, oldest first
	box_t box_now;            // box on the input channel

	int unsigned fail_count;
	int unsigned sent_count;
	int unsigned cycle_count;
	int unsigned gap_left;
	int unsigned stall_left;
	bit idle_on;
	verdict_t due;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle length for either side: mostly none, often a few cycles, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Signed random value from -2^k up to 2^k - 1.
	function automatic coord_t spread(int k);
		return coord_t'(int'($urandom()) >>> (31 - k));
	endfunction

	function automatic coord_t corner_value();
		case ($urandom_range(0, 7))
			0: return CMIN;
			1: return CMAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return CMIN + 32'sd1;
			6: return CMAX - 32'sd1;
			default: return coord_t'($urandom());
		endcase
	endfunction

	// Trimmed direction on one axis: floor(reach * (end - start) / 1.0), with the
	// reach clamped to one. The arithmetic shift of a signed value rounds down.
	function automatic longint trimmed_dir(int axis);
		longint reach;
		longint prod;
		reach = (seg.frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(seg.frac);
		prod = reach * (longint'(seg.stop[axis]) - longint'(seg.start[axis]));
		return prod >>> FRAC_SH;
	endfunction

	// One cross-product axis separates when |ma*db - mb*da| > ea*adb + eb*ada.
	// The products reach 68 bits, so the whole test runs at 128 bits.
	function automatic bit cross_apart(longint ma, longint mb, longint da, longint db,
			longint ea, longint eb, longint ada, longint adb);
		logic signed [127:0] wma, wmb, wda, wdb, wea, web, wada, wadb;
		logic signed [127:0] gap, slack;
		wma = ma;
		wmb = mb;
		wda = da;
		wdb = db;
		wea = ea;
		web = eb;
		wada = ada;
		wadb = adb;
		gap = wma * wdb - wmb * wda;
		if (gap < 0)
			gap = -gap;
		slack = wea * wadb + web * wada;
		return gap > slack;
	endfunction

	// Expected hit flag for one box against the shadow segment. Everything is kept
	// at twice the scale (m is the doubled center offset), so no halving is needed.
	function automatic logic predict_hit(box_t b);
		longint d[3], e[3], m[3], ad[3];
		longint am;
		logic hit;
		int i;
		hit = 1'b1;
		for (i = 0; i < 3; i++) begin
			d[i] = trimmed_dir(i);
			e[i] = longint'(b.hi[i]) - longint'(b.lo[i]);
			m[i] = 2 * longint'(seg.start[i]) + d[i] - longint'(b.lo[i]) - longint'(b.hi[i]);
			ad[i] = (d[i] < 0) ? -d[i] : d[i];
			am = (m[i] < 0) ? -m[i] : m[i];
			// Face axis: an inverted box gives a negative extent and is used as is.
			if (am > e[i] + ad[i])
				hit = 1'b0;
			// The epsilon of the cross axes is one LSB on the direction magnitude.
			ad[i] = ad[i] + 1;
		end
		if (hit && (cross_apart(m[1], m[2], d[1], d[2], e[1], e[2], ad[1], ad[2]) ||
				cross_apart(m[2], m[0], d[2], d[0], e[2], e[0], ad[2], ad[0]) ||
				cross_apart(m[0], m[1], d[0], d[1], e[0], e[1], ad[0], ad[1])))
			hit = 1'b0;
		return hit;
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic push_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
			coord_t hz);
		box_t b;
		b.lo = '{lx, ly, lz};
		b.hi = '{hx, hy, hz};
		boxes_waiting.push_back(b);
	endtask

	// Random box. Most are placed along the trimmed segment, a little beyond either end
	// and offset off the line, so that both verdicts and every separating axis come up.
	// The rest are fully random words or built from values at the ends of the range.
	function automatic box_t random_box();
		box_t b;
		coord_t tmp;
		longint t, c, off, lo, hi;
		int unsigned pick;
		int i, k;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 22);
		t = longint'($urandom_range(0, 73728)) - 4096;
		for (i = 0; i < 3; i++) begin
			if (pick < 65) begin
				c = longint'(seg.start[i]) + ((t * trimmed_dir(i)) >>> FRAC_SH);
				off = ($urandom_range(0, 3) == 0) ? 0 : (longint'(int'($urandom())) >>> (31 - k));
				lo = c + off - (longint'($urandom()) >> (32 - $urandom_range(0, 22)));
				hi = c + off + (longint'($urandom()) >> (32 - $urandom_range(0, 22)));
				b.lo[i] = coord_t'(lo);
				b.hi[i] = coord_t'(hi);
			end else if (pick < 85) begin
				b.lo[i] = coord_t'($urandom());
				b.hi[i] = coord_t'($urandom());
			end else begin
				b.lo[i] = corner_value();
				b.hi[i] = corner_value();
			end
		end
		// Now and then the corners of a placed box are swapped to turn it inside out.
		if (pick < 65 && $urandom_range(0, 15) == 0) begin
			for (i = 0; i < 3; i++) begin
				tmp = b.lo[i];
				b.lo[i] = b.hi[i];
				b.hi[i] = tmp;
			end
		end
		return b;
	endfunction

	// Register write: driven at one edge, taken by the block at the next. The shadow copy
	// is updated at once, which is safe because writes only happen with nothing in flight.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		if (idx <= REG_START_Z)
			seg.start[idx] = coord_t'(value);
		else if (idx <= REG_END_Z)
			seg.stop[idx - REG_END_X] = coord_t'(value);
		else if (idx == REG_REACH)
			seg.frac = value[FRAC_W-1:0];
	endtask

	task automatic finish_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic program_segment(coord_t a[3], coord_t z[3], logic [COORD_W-1:0] reach);
		int i;
		for (i = 0; i < 3; i++) begin
			write_reg(IDX_W'(REG_START_X + i), a[i]);
			write_reg(IDX_W'(REG_END_X + i), z[i]);
		end
		write_reg(REG_REACH, reach);
		// A stray write to the unused index must leave every register alone.
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, $urandom());
		finish_writes();
	endtask

	task automatic program_random_segment(seg_style_t style);
		coord_t a[3], z[3];
		logic [COORD_W-1:0] reach;
		int i;
		for (i = 0; i < 3; i++) begin
			case (style)
				SEG_WIDE: begin
					a[i] = coord_t'($urandom());
					z[i] = coord_t'($urandom());
				end
				SEG_MID: begin
					a[i] = spread(24);
					z[i] = spread(24);
				end
				SEG_NEAR: begin
					a[i] = spread(18);
					z[i] = spread(18);
				end
				SEG_CORNER: begin
					a[i] = corner_value();
					z[i] = corner_value();
				end
				default: begin
					a[i] = spread(22);
					z[i] = a[i];
				end
			endcase
		end
		// Half the time the whole segment; otherwise a part of it, nothing, or a value above
		// one (including junk in the upper data bits) that must clamp to one.
		case ($urandom_range(0, 7))
			4, 7: reach = $urandom_range(0, 65536);
			5: reach = 0;
			6: reach = $urandom();
			default: reach = FRAC_ONE;
		endcase
		program_segment(a, z, reach);
	endtask

	// Returns once nothing is queued, nothing is on the input channel and every
	// predicted hit word has come back.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (boxes_waiting.size() != 0 || box_ch.valid || hits_due.size() != 0);
	endtask

	// Driver: offers queued boxes on the input channel, holding each until it is taken,
	// with random gaps between words. A box is predicted at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_ch.valid <= 1'b0;
			gap_left = 0;
		end else if (!box_ch.valid || box_ch.ready) begin
			if (box_ch.valid) begin
				hits_due.push_back(verdict_t'{sent_count, predict_hit(box_now)});
				sent_count++;
			end
			if (gap_left > 0) begin
				gap_left--;
				box_ch.valid <= 1'b0;
			end else if (boxes_waiting.size() != 0) begin
				box_now = boxes_waiting.pop_front();
				box_ch.box_min_x <= box_now.lo[0];
				box_ch.box_min_y <= box_now.lo[1];
				box_ch.box_min_z <= box_now.lo[2];
				box_ch.box_max_x <= box_now.hi[0];
				box_ch.box_max_y <= box_now.hi[1];
				box_ch.box_max_z <= box_now.hi[2];
				box_ch.valid <= 1'b1;
				gap_left = idle_len();
			end else begin
				box_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: takes hit words with random back-pressure and checks each one against
	// the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (hit_ch.valid && hit_ch.ready) begin
				if (hits_due.size() == 0) begin
					report_mismatch($sformatf("hit word %0b with no box outstanding", hit_ch.hit));
				end else begin
					due = hits_due.pop_front();
					if (hit_ch.hit !== due.hit)
						report_mismatch($sformatf("box %0d: hit %b, predicted %b",
							due.serial, hit_ch.hit, due.hit));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				hit_ch.ready <= 1'b0;
			end else begin
				hit_ch.ready <= 1'b1;
				stall_left = idle_len();
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		coord_t a[3], z[3];
		int phase, n;

		// Every input known from time zero, with reset asserted at the start.
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		box_ch.valid = 1'b0;
		box_ch.box_min_x = '0;
		box_ch.box_min_y = '0;
		box_ch.box_min_z = '0;
		box_ch.box_max_x = '0;
		box_ch.box_max_y = '0;
		box_ch.box_max_z = '0;
		hit_ch.ready = 1'b0;
		seg.start = '{3{32'sd0}};
		seg.stop = '{3{32'sd0}};
		seg.frac = FRAC_ONE;
		idle_on = 1'b1;
		fail_count = 0;
		sent_count = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: a zero-length segment at the origin. Only the face axes can
		// separate, and the one-LSB slack still applies on the cross axes.
		push_box(-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
		push_box(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		push_box(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
		push_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		push_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		push_box(32'sh0064_0000, 32'sd0, 32'sd0, 32'sh0065_0000, 32'sd1, 32'sd1);

		// Longest possible segment, with an all-ones reach word that must clamp to one.
		wait_idle();
		a = '{CMIN, CMIN, CMIN};
		z = '{CMAX, CMAX, CMAX};
		program_segment(a, z, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'h5A5A_A5A5);
		finish_writes();
		push_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		push_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
		push_box(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		push_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
		push_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
		push_box(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);

		// Segment from (1,2,3) toward (5,-2,7) trimmed at one half, ending at (3,0,5).
		wait_idle();
		a = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000};
		z = '{32'sh0005_0000, -32'sh0002_0000, 32'sh0007_0000};
		program_segment(a, z, 32'h0000_8000);
		push_box(32'sh0002_8000, -32'sh0000_8000, 32'sh0004_8000,
			32'sh0003_8000, 32'sh0000_8000, 32'sh0005_8000);
		push_box(32'sh0004_8000, -32'sh0002_8000, 32'sh0006_8000,
			32'sh0005_8000, -32'sh0001_8000, 32'sh0007_8000);
		push_box(32'sh0002_0000, 32'sh0001_0000, 32'sh0004_0000,
			32'sh0002_0000, 32'sh0001_0000, 32'sh0004_0000);
		push_box(32'sh0002_0000, 32'sh0001_8000, 32'sh0004_0000,
			32'sh0002_8000, 32'sh0002_0000, 32'sh0004_8000);

		// Zero reach: the segment collapses onto its start point.
		wait_idle();
		program_segment(a, z, 32'h0000_0000);
		push_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
		push_box(32'sh0001_0001, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0001_0001, 32'sh0002_0000, 32'sh0003_0000);
		push_box(CMIN, CMIN, CMIN, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);

		// Random phases. Each one starts with the block drained, so the sender has
		// paused until every prediction was answered. The first phase runs without
		// any idling on either side.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			program_random_segment(seg_style_t'($urandom_range(0, 4)));
			for (n = 0; n < PHASE_ITEMS; n++)
				boxes_waiting.push_back(random_box());
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sbot_pkg.sv
hw/rtl/sbot_box_if.sv
hw/rtl/sbot_hit_if.sv
hw/rtl/sbot_cfg.sv
hw/rtl/sbot_front.sv
hw/rtl/sbot_cross.sv
hw/rtl/segment_box_overlap_test.sv
tb/tb.sv
